// ===== rtl/wots_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wots_pkg
// types and constants shared by the hash chain engine
// ----------------------------------------------------------------------------
package wots_pkg;

  localparam int unsigned MaxSteps = 15;
  localparam int unsigned RoundCount = 64;

  typedef enum logic [1:0] {
    ACT_KEYGEN = 2'd0,
    ACT_SIGN   = 2'd1,
    ACT_VERIFY = 2'd2,
    ACT_SPARE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  chain_index;
    logic        last_chain;
    logic [63:0] start_word0;
    logic [63:0] start_word1;
    logic [63:0] start_word2;
    logic [63:0] start_word3;
    logic [63:0] expect_word0;
    logic [63:0] expect_word1;
    logic [63:0] expect_word2;
    logic [63:0] expect_word3;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [63:0] out_word3;
    logic        chain_match;
    logic        verdict_ready;
    logic        signature_valid;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH_START,
    ST_ROUND,
    ST_HASH_END,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic hash_start;
    logic round;
    logic hash_end;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] steps;
  } dp_status_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/wots_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wots_ctrl
// sequencer: step count, 64 rounds per hash, input and output handshake
// ----------------------------------------------------------------------------
module wots_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  wots_pkg::dp_status_t  status,
  output wots_pkg::dp_cmd_t     cmd
);

  wots_pkg::state_t state, state_next;
  logic [3:0] steps, steps_next;
  logic [5:0] rnd, rnd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wots_pkg::ST_IDLE;
      steps <= '0;
      rnd   <= '0;
    end else begin
      state <= state_next;
      steps <= steps_next;
      rnd   <= rnd_next;
    end
  end

  always_comb begin
    state_next = state;
    steps_next = steps;
    rnd_next   = rnd;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      wots_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = wots_pkg::ST_HASH_START;
        end
      end
      wots_pkg::ST_HASH_START: begin
        if (steps == 4'd0 && status.steps == 4'd0) begin
          state_next = wots_pkg::ST_DONE;
        end else begin
          if (steps == 4'd0) steps_next = status.steps;
          else steps_next = steps;
          cmd.hash_start = 1'b1;
          rnd_next   = '0;
          state_next = wots_pkg::ST_ROUND;
        end
      end
      wots_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == 6'd63) state_next = wots_pkg::ST_HASH_END;
      end
      wots_pkg::ST_HASH_END: begin
        cmd.hash_end = 1'b1;
        steps_next   = steps - 4'd1;
        if (steps == 4'd1) state_next = wots_pkg::ST_DONE;
        else state_next = wots_pkg::ST_HASH_START;
      end
      wots_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        steps_next = '0;
        state_next = wots_pkg::ST_OUT;
      end
      wots_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = wots_pkg::ST_IDLE;
      end
      default: state_next = wots_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/wots_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wots_datapath
// one sha-256 round per cycle over a rolling 16-word schedule, verify compare
// ----------------------------------------------------------------------------
module wots_datapath #(
  parameter int unsigned CHAIN_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [63:0]           message_digest,
  input  wots_pkg::in_item_t    in_item,
  input  wots_pkg::dp_cmd_t     cmd,
  output wots_pkg::dp_status_t  status,
  output wots_pkg::out_item_t   out_item
);

  wots_pkg::in_item_t item;
  logic [31:0] v [8];
  logic [31:0] s [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic        all_matched;
  logic [3:0]  idx;
  logic [3:0]  idx_wrap [16];
  logic [3:0]  nib;
  logic [31:0] t1, t2, w_new;
  logic [255:0] chain_end, expect_all;
  logic        match;

  // chain index folded into the configured chain count
  for (genvar g = 0; g < 16; g++) begin : g_idx_wrap
    assign idx_wrap[g] = 4'(g % CHAIN_COUNT);
  end

  always_comb begin
    idx = idx_wrap[item.chain_index];
    nib = message_digest[{idx, 2'b00} +: 4];
    case (wots_pkg::action_t'(item.action))
      wots_pkg::ACT_SIGN:   status.steps = nib;
      wots_pkg::ACT_VERIFY: status.steps = 4'(wots_pkg::MaxSteps) - nib;
      default:              status.steps = 4'(wots_pkg::MaxSteps);
    endcase
  end

  always_comb begin
    t1 = s[7] + (wots_pkg::rotr(s[4], 6) ^ wots_pkg::rotr(s[4], 11) ^ wots_pkg::rotr(s[4], 25))
       + ((s[4] & s[5]) ^ (~s[4] & s[6])) + wots_pkg::RoundK[rnd] + w[0];
    t2 = (wots_pkg::rotr(s[0], 2) ^ wots_pkg::rotr(s[0], 13) ^ wots_pkg::rotr(s[0], 22))
       + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
    w_new = w[0] + (wots_pkg::rotr(w[1], 7) ^ wots_pkg::rotr(w[1], 18) ^ (w[1] >> 3))
          + w[9] + (wots_pkg::rotr(w[14], 17) ^ wots_pkg::rotr(w[14], 19) ^ (w[14] >> 10));
  end

  assign chain_end  = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  assign expect_all = {item.expect_word0, item.expect_word1, item.expect_word2,
                       item.expect_word3};
  assign match = (chain_end == expect_all);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      {v[0], v[1]} <= in_item.start_word0;
      {v[2], v[3]} <= in_item.start_word1;
      {v[4], v[5]} <= in_item.start_word2;
      {v[6], v[7]} <= in_item.start_word3;
    end
    if (cmd.hash_start) begin
      rnd <= '0;
      for (int i = 0; i < 8; i++) begin
        s[i] <= wots_pkg::InitH[i];
        w[i] <= v[i];
      end
      w[8] <= 32'h80000000;
      for (int i = 9; i < 15; i++) w[i] <= '0;
      w[15] <= 32'd256;
    end
    if (cmd.round) begin
      rnd <= rnd + 6'd1;
      s[7] <= s[6]; s[6] <= s[5]; s[5] <= s[4]; s[4] <= s[3] + t1;
      s[3] <= s[2]; s[2] <= s[1]; s[1] <= s[0]; s[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= w_new;
    end
    if (cmd.hash_end) begin
      for (int i = 0; i < 8; i++) v[i] <= wots_pkg::InitH[i] + s[i];
    end
    if (cmd.finish) begin
      out_item.out_word0 <= {v[0], v[1]};
      out_item.out_word1 <= {v[2], v[3]};
      out_item.out_word2 <= {v[4], v[5]};
      out_item.out_word3 <= {v[6], v[7]};
      if (item.action == wots_pkg::ACT_VERIFY) begin
        out_item.chain_match     <= match;
        out_item.verdict_ready   <= item.last_chain;
        out_item.signature_valid <= all_matched & match;
      end else begin
        out_item.chain_match     <= 1'b0;
        out_item.verdict_ready   <= 1'b0;
        out_item.signature_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      all_matched <= 1'b1;
    end else if (cmd.finish && item.action == wots_pkg::ACT_VERIFY) begin
      all_matched <= item.last_chain ? 1'b1 : (all_matched & match);
    end
  end

endmodule

// ===== rtl/winternitz_hash_chain_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winternitz_hash_chain_engine_unit
// wots chain engine: repeated sha-256 over a 32-byte chain value
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_ready take one item: action, chain index, last flag, start
//   value and expected public-key value. out_valid/out_ready return one item
//   per input: the chain end, plus match and verdict bits for verify.
//   cfg_we writes the 64-bit message digest; write only while idle.
// timing:
//   one sha-256 is 64 rounds on one shared round unit plus setup and
//   feed-forward. an item with n steps runs n hashes, up to 15 steps;
//   an item with zero steps goes straight to the result. one item is in
//   flight at a time; in_ready is high only when idle, in the cycle after
//   the result leaves.
// reset:
//   rst clears the sequencer, sets the verify run flag to all matched and
//   clears the message digest.
// stall:
//   the result holds on out while out_ready is low; no new item is taken
//   until the result leaves.
// ----------------------------------------------------------------------------
module winternitz_hash_chain_engine_unit #(
  parameter int unsigned CHAIN_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wots_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wots_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [63:0]          cfg_data
);

  logic [63:0]          message_digest;
  wots_pkg::dp_cmd_t    cmd;
  wots_pkg::dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) message_digest <= '0;
    else if (cfg_we) message_digest <= cfg_data;
  end

  wots_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wots_datapath #(
    .CHAIN_COUNT (CHAIN_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .message_digest (message_digest),
    .in_item        (in_data),
    .cmd            (cmd),
    .status         (status),
    .out_item       (out_data)
  );

endmodule
